// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on the rising clock edge, switched off while in reset
`define RHH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed");

// assertion that also holds during reset
`define RHH_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== design/rhh_pkg.sv =====
// types, constants and helpers for the robin-hood hash table
// no dependencies
`default_nettype none

package rhh_pkg;

  localparam int SLOTS  = 256;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int DIST_W = 8;
  localparam int CNT_W  = 9;
  localparam int HASH_W = 32;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = CNT_W'(192);
  localparam logic [CNT_W-1:0] SLOT_LIMIT        = CNT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NOT_FOUND = 3'd0,
    ST_FOUND     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_EV,
    S_INS_RD,
    S_INS_EV,
    S_REM_RD,
    S_REM_EV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [DIST_W-1:0] pdist;
  } slot_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nx;
    if (idx == IDX_W'(SLOTS - 1)) begin
      nx = '0;
    end else begin
      nx = idx + IDX_W'(1);
    end
    return nx;
  endfunction

endpackage

`default_nettype wire

// ===== design/robin_hood_hash_table.sv =====
// Robin-hood hash table with linear probing over 256 slots, one request at a time.
// Each probe step reads one slot from the slot memory and evaluates it the next
// cycle. A lookup, insert or remove probes slot by slot from its home slot and then
// hands over the result; before the handover, an insert of a new key with room
// walks on from the stop point up to and including the first empty slot, and a
// remove that finds its key shifts entries back up to the slot that ends the shift.
// Occupancy is kept in flip-flops, so all slots are empty immediately after reset
// and no clearing pass is needed. The limit register is to be written through the
// config port only while the table is idle; the block itself does not enforce
// this. Inserts are refused once the count reaches the limit or 255.
// depends on rhh_pkg and rhh_ram
`default_nettype none

module robin_hood_hash_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rhh_pkg::CNT_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [rhh_pkg::KEY_W-1:0]   key_i,
  input  wire logic [rhh_pkg::HASH_W-1:0]  key_hash_i,
  input  wire logic [rhh_pkg::VAL_W-1:0]   value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [rhh_pkg::VAL_W-1:0]        result_value_o,
  output logic [rhh_pkg::CNT_W-1:0]        entry_count_o
);
  import rhh_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d, prev_q, prev_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  val_q, val_d;
  opcode_e           op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, max_q;
  status_e           status_q, status_d;
  logic [VAL_W-1:0]  rval_q, rval_d;
  logic [SLOTS-1:0]  valid_q, valid_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  slot_t             mem_wdata, rd_slot;

  logic in_acc, occ, probe_stop, probe_hit, full, rem_stop;

  rhh_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(idx_q),
    .rdata_o(rd_slot)
  );

  assign in_acc     = in_valid_i && in_ready_o;
  assign occ        = valid_q[idx_q];
  assign probe_stop = !occ || (dist_q > rd_slot.pdist);
  assign probe_hit  = !probe_stop && (rd_slot.key == key_q);
  assign full       = (cnt_q >= max_q) || (cnt_q >= SLOT_LIMIT);
  // shift back ends at an empty slot or at an entry sitting at home
  assign rem_stop   = !occ || (rd_slot.pdist == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (opcode_e'(opcode_i) == OP_NONE) ? S_OUT : S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_d = S_PROBE_EV;
      S_PROBE_EV: begin
        if (probe_hit) begin
          state_d = (op_q == OP_REMOVE) ? S_REM_RD : S_OUT;
        end else if (probe_stop) begin
          state_d = (op_q == OP_INSERT && !full) ? S_INS_RD : S_OUT;
        end else begin
          state_d = S_PROBE_RD;
        end
      end
      S_INS_RD: state_d = S_INS_EV;
      S_INS_EV: state_d = occ ? S_INS_RD : S_OUT;
      S_REM_RD: state_d = S_REM_EV;
      S_REM_EV: state_d = rem_stop ? S_OUT : S_REM_RD;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    idx_d     = idx_q;
    prev_d    = prev_q;
    dist_d    = dist_q;
    key_d     = key_q;
    val_d     = val_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    rval_d    = rval_q;
    valid_d   = valid_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '{key: key_q, value: val_q, pdist: dist_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d    = key_hash_i[IDX_W-1:0];
          dist_d   = '0;
          key_d    = key_i;
          val_d    = value_i;
          op_d     = opcode_e'(opcode_i);
          status_d = ST_NOT_FOUND;
          rval_d   = '0;
        end
      end
      S_PROBE_EV: begin
        if (probe_hit) begin
          rval_d = rd_slot.value;
          unique case (op_q)
            OP_INSERT: status_d = ST_PRESENT;
            OP_REMOVE: begin
              status_d = ST_FOUND;
              prev_d   = idx_q;
              idx_d    = next_idx(idx_q);
            end
            default: status_d = ST_FOUND;
          endcase
        end else if (probe_stop) begin
          if (op_q == OP_INSERT) begin
            status_d = full ? ST_FULL : ST_INSERTED;
          end
        end else begin
          idx_d  = next_idx(idx_q);
          dist_d = dist_q + DIST_W'(1);
        end
      end
      S_INS_EV: begin
        if (!occ) begin
          mem_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          cnt_d          = cnt_q + CNT_W'(1);
        end else if (dist_q > rd_slot.pdist) begin
          // carried entry is further from home: take the slot, carry the resident
          mem_we = 1'b1;
          key_d  = rd_slot.key;
          val_d  = rd_slot.value;
          dist_d = rd_slot.pdist + DIST_W'(1);
          idx_d  = next_idx(idx_q);
        end else begin
          dist_d = dist_q + DIST_W'(1);
          idx_d  = next_idx(idx_q);
        end
      end
      S_REM_EV: begin
        if (rem_stop) begin
          valid_d[prev_q] = 1'b0;
          cnt_d           = cnt_q - CNT_W'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = '{key: rd_slot.key, value: rd_slot.value,
                        pdist: rd_slot.pdist - DIST_W'(1)};
          prev_d    = idx_q;
          idx_d     = next_idx(idx_q);
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    out_valid_o    = (state_q == S_OUT);
    cfg_ready_o    = 1'b1;
    status_o       = status_q;
    result_value_o = rval_q;
    entry_count_o  = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      max_q   <= MAX_ENTRIES_RESET;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    prev_q   <= prev_d;
    dist_q   <= dist_d;
    key_q    <= key_d;
    val_q    <= val_d;
    op_q     <= op_d;
    status_q <= status_d;
    rval_q   <= rval_d;
  end

endmodule

`default_nettype wire

// ===== design/rhh_ram.sv =====
// single-port-write, single-port-read synchronous slot memory
// registered read; no package dependency
`default_nettype none

module rhh_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/rhh_checker.sv =====
// port-level checks for the robin-hood hash table, bound to the top level
// depends on rhh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rhh_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [2:0]                status_o,
  input wire logic [rhh_pkg::CNT_W-1:0] entry_count_o
);
  import rhh_pkg::*;

  // a pending result holds until taken
  `RHH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  // one request in flight: no new request while a result waits
  `RHH_ASSERT(a_one_request, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `RHH_ASSERT(a_status_code, clk_i, rst_ni, out_valid_o |-> status_o <= ST_FULL)
  `RHH_ASSERT(a_insert_count, clk_i, rst_ni,
    out_valid_o && status_o == ST_INSERTED |-> entry_count_o != '0 && entry_count_o <= SLOT_LIMIT)

endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .entry_count_o(entry_count_o)
);

`default_nettype wire
